// ===== design/lbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lbs_pkg;
  localparam int JOINT_COUNT = 64;
  localparam int FRAC_BITS = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int ELEMS = 12;
  localparam int SUM_W = 48;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [5:0]        joint;
    logic [3:0]        element;
    logic signed [31:0] matrix_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [16:0]       weight;
    logic              last_of_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
  } out_item_t;

  // Queued command: classified by the front end.
  typedef struct packed {
    logic               apply;
    logic               use_joint;
    logic               last;
    logic [5:0]         joint;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [16:0]        weight;
  } cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sh00007fffffffffff) return 48'sh7fffffffffff;
    if (v < -64'sh0000800000000000) return 48'sh800000000000;
    return v[47:0];
  endfunction
endpackage
`default_nettype wire

// ===== design/lbs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface lbs_in_if;
  logic valid;
  logic ready;
  lbs_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lbs_out_if;
  logic valid;
  logic ready;
  lbs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/lbs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Loads go straight to the table; influences are queued for the back end.
// A load waits until the queue is empty and the back end is idle, so a new
// transform never overtakes an influence that still has to read the old one.
module lbs_front #(
  parameter int JOINT_COUNT = lbs_pkg::JOINT_COUNT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  lbs_in_if.sink                 in_i,
  output lbs_pkg::cmd_t          cmd_o,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output logic                   wr_en_o,
  output logic [$clog2(JOINT_COUNT*lbs_pkg::ELEMS)-1:0] wr_addr_o,
  output logic [31:0]            wr_data_o
);
  localparam int AW = $clog2(JOINT_COUNT*lbs_pkg::ELEMS);
  localparam int DEPTH = 2;
  lbs_pkg::cmd_t fifo_q [DEPTH];
  logic [0:0] wp_q, rp_q;
  logic [1:0] cnt_q;
  logic acc, push, pop, jok;

  assign in_i.ready = (in_i.data.operation == lbs_pkg::OP_LOAD)
                      ? ((cnt_q == 2'd0) && cmd_ready_i)
                      : (cnt_q != 2'(DEPTH));
  assign acc = in_i.valid && in_i.ready;
  assign jok = 32'(in_i.data.joint) < JOINT_COUNT;
  assign push = acc && (in_i.data.operation == lbs_pkg::OP_APPLY);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = fifo_q[rp_q];

  assign wr_en_o = acc && (in_i.data.operation == lbs_pkg::OP_LOAD) && jok
                   && (in_i.data.element < 4'(lbs_pkg::ELEMS));
  assign wr_addr_o = AW'(32'(in_i.data.joint) * lbs_pkg::ELEMS + 32'(in_i.data.element));
  assign wr_data_o = in_i.data.matrix_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q].apply <= 1'b1;
      fifo_q[wp_q].use_joint <= jok;
      fifo_q[wp_q].last <= in_i.data.last_of_vertex;
      fifo_q[wp_q].joint <= in_i.data.joint;
      fifo_q[wp_q].pos_x <= in_i.data.pos_x;
      fifo_q[wp_q].pos_y <= in_i.data.pos_y;
      fifo_q[wp_q].pos_z <= in_i.data.pos_z;
      fifo_q[wp_q].weight <= in_i.data.weight;
    end
  end
endmodule
`default_nettype wire

// ===== design/lbs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequencer: 12 table reads, 9 products, 3 weightings, then accumulate.
module lbs_back #(
  parameter int JOINT_COUNT = lbs_pkg::JOINT_COUNT,
  parameter int FRAC_BITS   = lbs_pkg::FRAC_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lbs_pkg::cmd_t     cmd_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  wire logic              wr_en_i,
  input  wire logic [$clog2(JOINT_COUNT*lbs_pkg::ELEMS)-1:0] wr_addr_i,
  input  wire logic [31:0]       wr_data_i,
  lbs_out_if.source              out_o
);
  localparam int AW = $clog2(JOINT_COUNT*lbs_pkg::ELEMS);
  localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_OUT = 2'd2;
  logic [31:0] mem [JOINT_COUNT*lbs_pkg::ELEMS];
  logic [31:0] rd_q;
  logic [1:0] st_q;
  logic [4:0] step_q;        // read index issued this step
  lbs_pkg::cmd_t c_q;
  logic signed [63:0] acc_q;  // row accumulator
  logic signed [31:0] crow_q [3];
  logic signed [47:0] sx_q, sy_q, sz_q;
  logic signed [31:0] pk;
  logic [3:0] ridx;
  logic [1:0] row, col;
  logic signed [63:0] prod, rnd;
  logic signed [31:0] cr;
  logic signed [63:0] wprod, contrib;
  logic [1:0] wrow;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    rd_q <= mem[AW'(32'(c_q.joint) * lbs_pkg::ELEMS + 32'(step_q[3:0]))];
  end

  // Data for element (step_q-1) is in rd_q.
  assign ridx = 4'(step_q - 5'd1);
  assign row = 2'(ridx / 4);
  assign col = 2'(ridx % 4);
  always_comb begin
    case (col)
      2'd0: pk = c_q.pos_x;
      2'd1: pk = c_q.pos_y;
      default: pk = c_q.pos_z;
    endcase
  end
  assign prod = $signed(rd_q) * pk;
  assign rnd = (prod + (64'sd1 <<< (FRAC_BITS-1))) >>> FRAC_BITS;
  assign cr = lbs_pkg::sat32(acc_q + 64'($signed(rd_q)));
  // weighting steps 13..15 use crow
  assign wrow = 2'(step_q - 5'd13);
  assign wprod = $signed({1'b0, c_q.weight}) * crow_q[wrow];
  assign contrib = (wprod + 64'sd32768) >>> lbs_pkg::WEIGHT_BITS;

  assign cmd_ready_o = (st_q == S_IDLE);
  assign out_o.valid = (st_q == S_OUT);
  assign out_o.data.new_x = lbs_pkg::sat32(64'(sx_q));
  assign out_o.data.new_y = lbs_pkg::sat32(64'(sy_q));
  assign out_o.data.new_z = lbs_pkg::sat32(64'(sz_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      step_q <= '0;
      sx_q <= '0;
      sy_q <= '0;
      sz_q <= '0;
    end else begin
      case (st_q)
        S_IDLE: if (cmd_valid_i) begin
          st_q <= S_RUN;
          step_q <= '0;
        end
        S_RUN: begin
          step_q <= step_q + 5'd1;
          if (!c_q.use_joint || step_q == 5'd15) begin
            st_q <= c_q.last ? S_OUT : S_IDLE;
          end
          if (c_q.use_joint && step_q >= 5'd13) begin
            case (wrow)
              2'd0: sx_q <= lbs_pkg::sat48(64'(sx_q) + contrib);
              2'd1: sy_q <= lbs_pkg::sat48(64'(sy_q) + contrib);
              default: sz_q <= lbs_pkg::sat48(64'(sz_q) + contrib);
            endcase
          end
        end
        S_OUT: if (out_o.ready) begin
          st_q <= S_IDLE;
          sx_q <= '0;
          sy_q <= '0;
          sz_q <= '0;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && cmd_valid_i) c_q <= cmd_i;
    if (st_q == S_RUN && step_q >= 5'd1 && step_q <= 5'd12) begin
      if (col == 2'd3) begin
        crow_q[row] <= cr;
        acc_q <= '0;
      end else if (col == 2'd0) begin
        acc_q <= rnd;
      end else begin
        acc_q <= acc_q + rnd;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/linear_blend_skinning.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Linear blend skinning of mesh vertices.
// Input channel in_i carries one item per transfer: a load (operation 0)
// writes one element of a joint's 3x4 transform into the table, an apply
// (operation 1) adds weight*(R*p+t) of one influence to the running sum.
// The apply marked last_of_vertex emits the blended position on out_o.
// The back sequencer takes an apply in an idle cycle and runs 16 steps:
// twelve reads of the transform memory, one product per cycle, then three
// weightings; it takes no new apply until it is idle again, and an apply
// that closes a vertex holds it in the output state until the receiver is
// ready. An influence on an unknown joint runs one step.
// A two-entry queue sits between the front and the back, so new influences
// are taken while the back end is busy. A load transfers once
// the queue is empty and the back end is idle; until then it waits.
// Reset clears the sums and the queue; the table holds garbage until loaded.
// When the receiver stalls, the result holds on out_o and the back end
// waits; the front keeps accepting influences until the queue fills.
module linear_blend_skinning #(
  parameter int JOINT_COUNT = lbs_pkg::JOINT_COUNT,
  parameter int FRAC_BITS   = lbs_pkg::FRAC_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lbs_in_if.sink    in_i,
  lbs_out_if.source out_o
);
  localparam int AW = $clog2(JOINT_COUNT*lbs_pkg::ELEMS);
  lbs_pkg::cmd_t cmd;
  logic cmd_valid, cmd_ready, wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0] wr_data;

  lbs_front #(.JOINT_COUNT(JOINT_COUNT)) u_front (
    .clk_i, .rst_ni, .in_i,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data)
  );

  lbs_back #(.JOINT_COUNT(JOINT_COUNT), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data), .out_o
  );

  // A result waiting for the receiver holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data))
    else $error("result changed while stalled");
  // The back end never takes a command while a result is pending.
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !cmd_ready)
    else $error("command taken during output");
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  lbs_in_if  in_if ();
  lbs_out_if out_if ();

  linear_blend_skinning dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Own copy of the transform table and the running sums.
  logic signed [31:0]  xform_tbl [lbs_pkg::JOINT_COUNT*lbs_pkg::ELEMS];
  longint              blend_x, blend_y, blend_z;
  lbs_pkg::out_item_t  pending_pos [$];
  int                  fail_count = 0;
  int                  loaded_joints [$];
  // Long receiver stalls are switched off for some stretches.
  bit                  sink_calm = 1'b0;

  function automatic longint clamp64(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One row of R*p + t, each product rounded half up, row saturated to 32 bits.
  function automatic longint xform_row(int base, int r, longint px, longint py, longint pz);
    longint acc;
    acc = 0;
    acc += (longint'(xform_tbl[base + r*4 + 0]) * px + 64'sd32768) >>> lbs_pkg::FRAC_BITS;
    acc += (longint'(xform_tbl[base + r*4 + 1]) * py + 64'sd32768) >>> lbs_pkg::FRAC_BITS;
    acc += (longint'(xform_tbl[base + r*4 + 2]) * pz + 64'sd32768) >>> lbs_pkg::FRAC_BITS;
    acc += longint'(xform_tbl[base + r*4 + 3]);
    return clamp64(acc, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint weigh_add(longint s, longint w, longint c);
    return clamp64(s + ((w * c + 64'sd32768) >>> lbs_pkg::WEIGHT_BITS),
                   -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
  endfunction

  // Update the table or the sums for one accepted transfer; queue the
  // blended position when the vertex closes.
  task automatic blend_influence(lbs_pkg::in_item_t it);
    int base;
    longint px, py, pz, w;
    lbs_pkg::out_item_t r;
    if (it.operation == lbs_pkg::OP_LOAD) begin
      if (it.element < lbs_pkg::ELEMS) begin
        xform_tbl[it.joint*lbs_pkg::ELEMS + it.element] = it.matrix_value;
      end
    end else begin
      base = it.joint * lbs_pkg::ELEMS;
      px = longint'(it.pos_x);
      py = longint'(it.pos_y);
      pz = longint'(it.pos_z);
      w  = longint'(it.weight);
      blend_x = weigh_add(blend_x, w, xform_row(base, 0, px, py, pz));
      blend_y = weigh_add(blend_y, w, xform_row(base, 1, px, py, pz));
      blend_z = weigh_add(blend_z, w, xform_row(base, 2, px, py, pz));
      if (it.last_of_vertex) begin
        r.new_x = 32'(clamp64(blend_x, -64'sd2147483648, 64'sd2147483647));
        r.new_y = 32'(clamp64(blend_y, -64'sd2147483648, 64'sd2147483647));
        r.new_z = 32'(clamp64(blend_z, -64'sd2147483648, 64'sd2147483647));
        pending_pos = {pending_pos, r};
        blend_x = 0;
        blend_y = 0;
        blend_z = 0;
      end
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Send one item; valid stays high afterwards so back-to-back transfers
  // never drop it within a step.
  task automatic send_item(lbs_pkg::in_item_t it, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    blend_influence(it);
  endtask

  function automatic logic signed [31:0] rand_word();
    int roll;
    roll = $urandom_range(0, 15);
    case (roll)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3, 4, 5, 6, 7, 8: return $signed($urandom_range(0, 262143)) - 131072;
      default: return $urandom;
    endcase
  endfunction

  function automatic lbs_pkg::in_item_t rand_noise_fields();
    lbs_pkg::in_item_t it;
    it.operation      = lbs_pkg::OP_LOAD;
    it.joint          = 6'($urandom);
    it.element        = 4'($urandom);
    it.matrix_value   = $urandom;
    it.pos_x          = $urandom;
    it.pos_y          = $urandom;
    it.pos_z          = $urandom;
    it.weight         = 17'($urandom);
    it.last_of_vertex = 1'($urandom);
    return it;
  endfunction

  task automatic load_joint(int j, bit identity);
    lbs_pkg::in_item_t it;
    for (int e = 0; e < lbs_pkg::ELEMS; e++) begin
      it = rand_noise_fields();
      it.operation = lbs_pkg::OP_LOAD;
      it.joint = 6'(j);
      it.element = 4'(e);
      if (identity) it.matrix_value = (e == 0 || e == 5 || e == 10) ? 32'sh10000 : 32'sd0;
      else it.matrix_value = rand_word();
      send_item(it, pick_gap());
    end
    if (!(j inside {loaded_joints})) loaded_joints = {loaded_joints, j};
  endtask

  function automatic logic [16:0] rand_weight();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 17'd0;
    if (roll == 1) return 17'd65536;
    if (roll == 2) return 17'd131071;
    return 17'($urandom_range(0, 65536));
  endfunction

  task automatic send_apply(int j, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic [16:0] w, bit last, int gap);
    lbs_pkg::in_item_t it;
    it = rand_noise_fields();
    it.operation = lbs_pkg::OP_APPLY;
    it.joint = 6'(j);
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.weight = w;
    it.last_of_vertex = last;
    send_item(it, gap);
  endtask

  // Hold the sender until every queued position has come out.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_pos.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    lbs_pkg::in_item_t it;
    load_joint(0, 1'b1);
    // Extreme positions through the identity, full, zero and maximum weights.
    send_apply(0, 32'sh7fffffff, 32'sh80000000, 32'sd0, 17'd65536, 1'b1, 0);
    send_apply(0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 17'd131071, 1'b1, 0);
    send_apply(0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 17'd0, 1'b1, 1);
    // Two influences whose running sum overflows 32 bits before the output clamp.
    send_apply(0, 32'sh7fffffff, 32'sh80000000, 32'sh12345, 17'd131071, 1'b0, 0);
    send_apply(0, 32'sh7fffffff, 32'sh80000000, 32'sh12345, 17'd131071, 1'b1, 0);
    // Loads with an element past the end of the transform are dropped.
    it = rand_noise_fields();
    it.joint = 6'd0;
    it.element = 4'd12;
    it.last_of_vertex = 1'b1;
    send_item(it, 0);
    it.element = 4'd15;
    send_item(it, 2);
    send_apply(0, 32'sh10000, 32'sh20000, 32'sh30000, 17'd32768, 1'b1, 0);
    drain();
  endtask

  // Loaded joints get new transforms between vertices.
  task automatic test_random(int n_items);
    int sent;
    int infl;
    int j;
    lbs_pkg::in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0: begin
          load_joint($urandom_range(0, lbs_pkg::JOINT_COUNT - 1), $urandom_range(0, 3) == 0);
          sent += lbs_pkg::ELEMS;
        end
        1: begin
          it = rand_noise_fields();
          it.element = 4'($urandom_range(12, 15));
          send_item(it, pick_gap());
          sent++;
        end
        2: begin
          it = rand_noise_fields();
          j = loaded_joints[$urandom_range(0, loaded_joints.size() - 1)];
          it.joint = 6'(j);
          it.element = 4'($urandom_range(0, lbs_pkg::ELEMS - 1));
          it.matrix_value = rand_word();
          send_item(it, pick_gap());
          sent++;
        end
        default: begin
          infl = $urandom_range(1, 4);
          for (int k = 0; k < infl; k++) begin
            j = loaded_joints[$urandom_range(0, loaded_joints.size() - 1)];
            send_apply(j, rand_word(), rand_word(), rand_word(), rand_weight(),
                       k == infl - 1, pick_gap());
          end
          sent += infl;
        end
      endcase
      if ($urandom_range(0, 49) == 0) drain();
    end
  endtask

  task automatic test_back_to_back();
    sink_calm = 1'b1;
    for (int k = 0; k < 40; k++)
      send_apply(loaded_joints[$urandom_range(0, loaded_joints.size() - 1)],
                 rand_word(), rand_word(), rand_word(), rand_weight(),
                 1'($urandom_range(0, 1)), 0);
    send_apply(0, 32'sd0, 32'sd0, 32'sd0, 17'd0, 1'b1, 0);
    drain();
    sink_calm = 1'b0;
  endtask

  // Receiver backpressure: mostly ready, short stalls, a few long ones.
  int sink_hold = 0;
  initial out_if.ready = 1'b0;
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_if.ready <= 1'b0;
      sink_hold <= (!sink_calm && $urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(0, 3);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Compare each output transfer with the oldest blended position.
  always @(posedge clk_i) begin
    lbs_pkg::out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_pos.size() == 0) begin
        $error("unexpected output transfer x=%0d y=%0d z=%0d",
               out_if.data.new_x, out_if.data.new_y, out_if.data.new_z);
        fail_count++;
      end else begin
        want = pending_pos.pop_front();
        if (out_if.data.new_x !== want.new_x) begin
          $error("new_x: expected %0d, actual %0d", want.new_x, out_if.data.new_x);
          fail_count++;
        end
        if (out_if.data.new_y !== want.new_y) begin
          $error("new_y: expected %0d, actual %0d", want.new_y, out_if.data.new_y);
          fail_count++;
        end
        if (out_if.data.new_z !== want.new_z) begin
          $error("new_z: expected %0d, actual %0d", want.new_z, out_if.data.new_z);
          fail_count++;
        end
      end
    end
  end

  initial begin
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    blend_x = 0;
    blend_y = 0;
    blend_z = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300);
    test_back_to_back();
    test_random(260);
    drain();
    // Let the back end settle before the verdict.
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending_pos.size() == 0) begin
      $display("** linear_blend_skinning: PASSED **");
    end else begin
      $display("** linear_blend_skinning: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** linear_blend_skinning: FAILED **");
    $finish;
  end
endmodule

// ===== linear_blend_skinning.f =====
design/lbs_pkg.sv
design/lbs_if.sv
design/lbs_front.sv
design/lbs_back.sv
design/linear_blend_skinning.sv
dv/tb.sv
